// File: rtl/fnvlp_pkg.sv
// ----------------------------------------------------------------------------
// fnvlp_pkg
// Shared types and constants for the FNV-1a linear-probe glyph map.
// ----------------------------------------------------------------------------
package fnvlp_pkg;

	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_KEY_ZERO  = 3'd4
	} status_t;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_STORE  = 1'b1;

	localparam logic [31:0] FNV_OFFSET     = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME      = 32'h0100_0193;
	localparam logic [8:0]  LOAD_LIMIT_RST = 9'd192;

	// texture id in the low half, advance in the high half
	typedef struct packed {
		logic [31:0] advance;
		logic [31:0] texture_id;
	} id_adv_t;

	// width, height, bearing x, bearing y from the low bits up
	typedef struct packed {
		logic signed [15:0] bearing_y;
		logic signed [15:0] bearing_x;
		logic        [15:0] height;
		logic        [15:0] width;
	} geom_t;

	typedef struct packed {
		logic        key_wr;
		logic        rec_wr;
		logic [31:0] key;
		id_adv_t     ia;
		geom_t       geom;
	} store_wr_t;

endpackage

// File: rtl/fnvlp_hash.sv
// ----------------------------------------------------------------------------
// fnvlp_hash
// Multicycle FNV-1a over the four key bytes, then reduction to a home slot.
// ----------------------------------------------------------------------------
module fnvlp_hash
	import fnvlp_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [31:0]                   key,
	output logic                          done,
	output logic [$clog2(CAPACITY)-1:0]   home
);

	localparam int         IDX_W = $clog2(CAPACITY);
	localparam bit         POW2  = (CAPACITY & (CAPACITY - 1)) == 0;
	localparam logic [IDX_W:0] CAP_R = (IDX_W + 1)'(CAPACITY);

	logic [31:0]      h_q;
	logic [31:0]      key_sh_q;
	logic [2:0]       step_q;
	logic             hash_busy_q;
	logic             mod_busy_q;
	logic             done_q;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W-1:0] rem_nxt;

	// four bits of restoring reduction per cycle
	always_comb begin
		logic [IDX_W:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < 4; i++) begin
			r = {r[IDX_W-1:0], h_q[31-i]};
			if (r >= CAP_R)
				r = r - CAP_R;
		end
		rem_nxt = r[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_busy_q <= 1'b0;
			mod_busy_q  <= 1'b0;
			done_q      <= 1'b0;
			step_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				hash_busy_q <= 1'b1;
				step_q      <= '0;
			end else if (hash_busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd3) begin
					hash_busy_q <= 1'b0;
					step_q      <= '0;
					if (POW2)
						done_q <= 1'b1;
					else
						mod_busy_q <= 1'b1;
				end
			end else if (mod_busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) begin
					mod_busy_q <= 1'b0;
					done_q     <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q      <= FNV_OFFSET;
			key_sh_q <= key;
			rem_q    <= '0;
		end else if (hash_busy_q) begin
			h_q      <= (h_q ^ {24'd0, key_sh_q[7:0]}) * FNV_PRIME;
			key_sh_q <= {8'd0, key_sh_q[31:8]};
		end else if (mod_busy_q) begin
			h_q   <= {h_q[27:0], 4'd0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign home = POW2 ? h_q[IDX_W-1:0] : rem_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("hash done held longer than one cycle");

	a_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hash_busy_q && mod_busy_q))
		else $error("hash and reduction active together");

endmodule

// File: rtl/fnvlp_store.sv
// ----------------------------------------------------------------------------
// fnvlp_store
// Key, id/advance and geometry memories: one write and one read per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module fnvlp_store
	import fnvlp_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic                        clk,
	input  logic [$clog2(CAPACITY)-1:0] rd_addr,
	input  logic [$clog2(CAPACITY)-1:0] wr_addr,
	input  store_wr_t                   wr,
	output logic [31:0]                 rd_key,
	output id_adv_t                     rd_ia,
	output geom_t                       rd_geom
);

	logic [31:0] key_mem  [CAPACITY];
	id_adv_t     ia_mem   [CAPACITY];
	geom_t       geom_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.key_wr)
			key_mem[wr_addr] <= wr.key;
		rd_key <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.rec_wr)
			ia_mem[wr_addr] <= wr.ia;
		rd_ia <= ia_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.rec_wr)
			geom_mem[wr_addr] <= wr.geom;
		rd_geom <= geom_mem[rd_addr];
	end

endmodule

// File: rtl/fnv_linear_probe_hash_map.sv
// ----------------------------------------------------------------------------
// fnv_linear_probe_hash_map
// Open-addressing glyph map, 32-bit keys, FNV-1a home slot, linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one lookup or insert/update per
//   transaction; output channel (out_valid/out_ready) returns one status and
//   record per transaction. cfg_we/cfg_wdata write load_limit.
//   Items are worked one at a time. The hash does one FNV multiply per key
//   byte, followed by a slot reduction when CAPACITY is not a power of two.
//   The probe then reads one slot per cycle from the key memory, whose read
//   data is registered. A new item is accepted only once the previous
//   result has left for the output register; key zero skips hash and probe.
//   A finished result sits in the output register while the next item is
//   already hashed and probed; if the receiver stalls, the block holds the
//   next result until the output register frees.
//   After reset the key memory is swept to empty, one slot a cycle;
//   in_ready stays low until the sweep ends, config writes still land.
// ----------------------------------------------------------------------------
module fnv_linear_probe_hash_map
	import fnvlp_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [8:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [31:0]        key,
	input  logic [31:0]        new_texture_id,
	input  logic [15:0]        new_width,
	input  logic [15:0]        new_height,
	input  logic signed [15:0] new_bearing_x,
	input  logic signed [15:0] new_bearing_y,
	input  logic [31:0]        new_advance,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [31:0]        texture_id,
	output logic [15:0]        glyph_width,
	output logic [15:0]        glyph_height,
	output logic signed [15:0] bearing_x,
	output logic signed [15:0] bearing_y,
	output logic [31:0]        advance
);

	localparam int               IDX_W    = $clog2(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HASH  = 5'b00100,
		S_PROBE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic [IDX_W-1:0] issue_addr_q;
	logic [IDX_W-1:0] addr_s1;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] visited_q;
	logic [8:0]       load_limit_q;
	logic [8:0]       entry_count_q;

	logic             op_q;
	logic [31:0]      key_q;
	id_adv_t          ia_q;
	geom_t            geom_q;

	status_t          res_status_q;
	id_adv_t          res_ia_q;
	geom_t            res_geom_q;

	logic             out_valid_q;
	status_t          out_status_q;
	id_adv_t          out_ia_q;
	geom_t            out_geom_q;

	logic             accept;
	logic             hash_start;
	logic             hash_done;
	logic [IDX_W-1:0] home;

	logic [31:0]      rd_key;
	id_adv_t          rd_ia;
	geom_t            rd_geom;
	store_wr_t        st_wr;
	logic [IDX_W-1:0] wr_addr;

	logic             match;
	logic             empty;
	logic             resolve;
	logic             room;
	logic             ins_wr;
	logic             ins_new;
	status_t          res_status_nxt;
	logic             out_load;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign hash_start = accept && (key != '0);

	fnvlp_hash #(
		.CAPACITY(CAPACITY)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   (key),
		.done  (hash_done),
		.home  (home)
	);

	fnvlp_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk    (clk),
		.rd_addr(issue_addr_q),
		.wr_addr(wr_addr),
		.wr     (st_wr),
		.rd_key (rd_key),
		.rd_ia  (rd_ia),
		.rd_geom(rd_geom)
	);

	// probe decision on the slot read last cycle
	always_comb begin
		match   = (rd_key == key_q);
		empty   = (rd_key == '0);
		resolve = (state_q == S_PROBE) && rd_vld_s1 &&
		          (match || empty || (visited_q == LAST_IDX));
		room    = ({1'b0, entry_count_q} + 10'd1) <= {1'b0, load_limit_q};
		ins_new = resolve && (op_q == OP_STORE) && empty && room;
		ins_wr  = resolve && (op_q == OP_STORE) && (match || (empty && room));
		if (op_q == OP_LOOKUP) begin
			res_status_nxt = match ? ST_FOUND : ST_NOT_FOUND;
		end else if (match) begin
			res_status_nxt = ST_FOUND;
		end else if (empty && room) begin
			res_status_nxt = ST_INSERTED;
		end else begin
			res_status_nxt = ST_FULL;
		end
	end

	always_comb begin
		st_wr.key_wr = (state_q == S_CLEAR) || ins_wr;
		st_wr.rec_wr = ins_wr;
		st_wr.key    = (state_q == S_CLEAR) ? '0 : key_q;
		st_wr.ia     = ia_q;
		st_wr.geom   = geom_q;
		wr_addr      = (state_q == S_CLEAR) ? clr_addr_q : addr_s1;
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_addr_q    <= '0;
			rd_vld_s1     <= 1'b0;
			visited_q     <= '0;
			load_limit_q  <= LOAD_LIMIT_RST;
			entry_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we)
				load_limit_q <= cfg_wdata;
			if (ins_new)
				entry_count_q <= entry_count_q + 9'd1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_IDX)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept)
						state_q <= (key == '0) ? S_DONE : S_HASH;
				end
				S_HASH: begin
					if (hash_done) begin
						state_q   <= S_PROBE;
						rd_vld_s1 <= 1'b0;
						visited_q <= '0;
					end
				end
				S_PROBE: begin
					if (resolve) begin
						state_q   <= S_DONE;
						rd_vld_s1 <= 1'b0;
					end else begin
						rd_vld_s1 <= 1'b1;
						if (rd_vld_s1)
							visited_q <= visited_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q               <= operation;
			key_q              <= key;
			ia_q.texture_id    <= new_texture_id;
			ia_q.advance       <= new_advance;
			geom_q.width       <= new_width;
			geom_q.height      <= new_height;
			geom_q.bearing_x   <= new_bearing_x;
			geom_q.bearing_y   <= new_bearing_y;
			res_status_q       <= ST_KEY_ZERO;
			res_ia_q           <= '0;
			res_geom_q         <= '0;
		end
		if (state_q == S_HASH && hash_done) begin
			issue_addr_q <= home;
		end else if (state_q == S_PROBE) begin
			issue_addr_q <= (issue_addr_q == LAST_IDX) ? '0 : issue_addr_q + 1'b1;
			addr_s1      <= issue_addr_q;
		end
		if (resolve) begin
			res_status_q <= res_status_nxt;
			res_ia_q     <= ((op_q == OP_LOOKUP) && match) ? rd_ia : '0;
			res_geom_q   <= ((op_q == OP_LOOKUP) && match) ? rd_geom : '0;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_ia_q     <= res_ia_q;
			out_geom_q   <= res_geom_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign texture_id   = out_ia_q.texture_id;
	assign advance      = out_ia_q.advance;
	assign glyph_width  = out_geom_q.width;
	assign glyph_height = out_geom_q.height;
	assign bearing_x    = out_geom_q.bearing_x;
	assign bearing_y    = out_geom_q.bearing_y;

	a_no_zero_key_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(st_wr.key_wr && (state_q != S_CLEAR)) |-> (key_q != '0))
		else $error("zero key written outside clearing sweep");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ins_new |=> (entry_count_q == 9'($past(entry_count_q) + 9'd1)))
		else $error("entry count did not advance on new insert");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(entry_count_q) <= 32'(CAPACITY)))
		else $error("entry count exceeds capacity");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !ins_wr)
		else $error("insert write during clearing sweep");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FNV-1a linear-probe glyph map. A mirror of the
// slot table predicts the status and record of every accepted transaction.
// Traffic: a directed opening (reserved key, extreme records, wrap-around
// clusters), then random lookups and inserts under several load limits.
// The table is finally driven completely full.
// ----------------------------------------------------------------------------
module testbench;
	import fnvlp_pkg::*;

	localparam int   CAP            = 256;
	localparam int   WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic        op;
		logic [31:0] key;
		id_adv_t     ia;
		geom_t       geom;
	} glyph_req_t;

	typedef struct packed {
		logic [2:0] status;
		id_adv_t    ia;
		geom_t      geom;
	} glyph_reply_t;

	function automatic logic [31:0] fnv1a(logic [31:0] k);
		logic [31:0] h;
		h = FNV_OFFSET;
		for (int i = 0; i < 4; i++)
			h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
		return h;
	endfunction

	// Mirror of the slot table; predicts one reply per request.
	class glyph_map_tracker;
		logic [31:0]  slot_key [CAP];
		id_adv_t      slot_ia [CAP];
		geom_t        slot_geom [CAP];
		int unsigned  entries;
		logic [8:0]   limit;
		glyph_reply_t glyph_replies[$];
		int unsigned  errors;
		int unsigned  checked;

		function new();
			foreach (slot_key[i])
				slot_key[i] = '0;
			entries = 0;
			limit   = LOAD_LIMIT_RST;
			errors  = 0;
			checked = 0;
		endfunction

		function void note_request(glyph_req_t req);
			glyph_reply_t ans;
			int unsigned  idx;
			int unsigned  steps;
			bit           hit;
			ans = '0;
			hit = 1'b0;
			if (req.key == '0) begin
				ans.status = ST_KEY_ZERO;
			end else begin
				idx   = fnv1a(req.key) % CAP;
				steps = 0;
				while (!hit && steps < CAP) begin
					if (slot_key[idx] == '0 || slot_key[idx] == req.key) begin
						hit = 1'b1;
					end else begin
						idx = (idx + 1) % CAP;
						steps++;
					end
				end
				if (req.op == OP_LOOKUP) begin
					if (hit && slot_key[idx] != '0) begin
						ans.status = ST_FOUND;
						ans.ia     = slot_ia[idx];
						ans.geom   = slot_geom[idx];
					end else begin
						ans.status = ST_NOT_FOUND;
					end
				end else if (!hit) begin
					ans.status = ST_FULL;
				end else if (slot_key[idx] == '0 && entries + 1 > limit) begin
					ans.status = ST_FULL;
				end else begin
					if (slot_key[idx] == '0) begin
						entries++;
						ans.status = ST_INSERTED;
					end else begin
						ans.status = ST_FOUND;
					end
					slot_key[idx]  = req.key;
					slot_ia[idx]   = req.ia;
					slot_geom[idx] = req.geom;
				end
			end
			glyph_replies.push_back(ans);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("mismatch on %s: expected %h, got %h", name, want, got);
			end
		endfunction

		function void check_reply(glyph_reply_t got);
			glyph_reply_t want;
			if (glyph_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transaction on output: status %0d", got.status);
			end else begin
				want = glyph_replies.pop_front();
				compare_field("status", 32'(want.status), 32'(got.status));
				compare_field("texture_id", want.ia.texture_id, got.ia.texture_id);
				compare_field("glyph_width", 32'(want.geom.width), 32'(got.geom.width));
				compare_field("glyph_height", 32'(want.geom.height),
					32'(got.geom.height));
				compare_field("bearing_x", 32'(want.geom.bearing_x),
					32'(got.geom.bearing_x));
				compare_field("bearing_y", 32'(want.geom.bearing_y),
					32'(got.geom.bearing_y));
				compare_field("advance", want.ia.advance, got.ia.advance);
				checked++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [8:0]         cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic               operation;
	logic [31:0]        key;
	logic [31:0]        new_texture_id;
	logic [15:0]        new_width;
	logic [15:0]        new_height;
	logic signed [15:0] new_bearing_x;
	logic signed [15:0] new_bearing_y;
	logic [31:0]        new_advance;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         status;
	logic [31:0]        texture_id;
	logic [15:0]        glyph_width;
	logic [15:0]        glyph_height;
	logic signed [15:0] bearing_x;
	logic signed [15:0] bearing_y;
	logic [31:0]        advance;

	glyph_map_tracker sb = new();

	int unsigned tx_count       = 0;
	int unsigned stalled_cycles = 0;
	bit          tx_quiet       = 1'b0;
	bit          rx_quiet       = 1'b0;
	bit          rx_hold_req    = 1'b0;
	logic [31:0] stored_keys[$];
	int unsigned hot_slot[4];

	fnv_linear_probe_hash_map #(
		.CAPACITY(CAP)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.key           (key),
		.new_texture_id(new_texture_id),
		.new_width     (new_width),
		.new_height    (new_height),
		.new_bearing_x (new_bearing_x),
		.new_bearing_y (new_bearing_y),
		.new_advance   (new_advance),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.texture_id    (texture_id),
		.glyph_width   (glyph_width),
		.glyph_height  (glyph_height),
		.bearing_x     (bearing_x),
		.bearing_y     (bearing_y),
		.advance       (advance)
	);

	always #5 clk = ~clk;

	// Sample both channels and the config port at the edge.
	always @(posedge clk) begin
		glyph_req_t   req;
		glyph_reply_t got;
		if (arst_n && cfg_we)
			sb.limit = cfg_wdata;
		if (arst_n && in_valid && in_ready) begin
			req = {operation, key, new_advance, new_texture_id,
				new_bearing_y, new_bearing_x, new_height, new_width};
			sb.note_request(req);
		end
		if (arst_n && out_valid && out_ready) begin
			got = {status, advance, texture_id, bearing_y, bearing_x,
				glyph_height, glyph_width};
			sb.check_reply(got);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
	end

	initial begin
		while (stalled_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("[fnv_linear_probe_hash_map] ERROR");
		$finish;
	end

	// Receiver: random back-pressure plus one long hold-off on request.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = 250;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= rx_quiet || $urandom_range(99) >= 32;
			end
		end
	end

	function automatic id_adv_t rand_ia();
		return {$urandom, $urandom};
	endfunction

	function automatic geom_t rand_geom();
		return {$urandom, $urandom};
	endfunction

	// Random nonzero key whose home slot is the given one.
	function automatic logic [31:0] key_for_slot(int unsigned slot);
		logic [31:0] k;
		k = $urandom;
		while (k == '0 || fnv1a(k) % CAP != slot)
			k = $urandom;
		return k;
	endfunction

	task automatic send_item(input logic op, input logic [31:0] k, input id_adv_t ia,
		input geom_t g);
		while (!tx_quiet && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		key            <= k;
		new_texture_id <= ia.texture_id;
		new_advance    <= ia.advance;
		new_width      <= g.width;
		new_height     <= g.height;
		new_bearing_x  <= g.bearing_x;
		new_bearing_y  <= g.bearing_y;
		do
			@(posedge clk);
		while (!in_ready);
		tx_count++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.checked < tx_count)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_limit(input logic [8:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic pick_hot_slots();
		hot_slot[0] = CAP - 1;
		for (int i = 1; i < 4; i++)
			hot_slot[i] = $urandom_range(CAP - 1);
	endtask

	// Mix: known keys, clustered keys on a few home slots, fresh keys, key zero.
	task automatic run_random(input int unsigned n);
		int unsigned r;
		logic        op;
		logic [31:0] k;
		for (int unsigned i = 0; i < n; i++) begin
			r  = $urandom_range(99);
			op = 1'($urandom_range(1));
			if (r < 3)
				k = '0;
			else if (r < 50 && stored_keys.size() != 0)
				k = stored_keys[$urandom_range(stored_keys.size() - 1)];
			else if (r < 70)
				k = key_for_slot(hot_slot[$urandom_range(3)]);
			else
				k = $urandom;
			if (op == OP_STORE && k != '0)
				stored_keys.push_back(k);
			send_item(op, k, rand_ia(), rand_geom());
		end
	endtask

	initial begin
		logic [31:0] wrap_key[4];
		logic [31:0] k;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		in_valid       <= 1'b0;
		operation      <= OP_LOOKUP;
		key            <= '0;
		new_texture_id <= '0;
		new_width      <= '0;
		new_height     <= '0;
		new_bearing_x  <= '0;
		new_bearing_y  <= '0;
		new_advance    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening at the reset load limit
		send_item(OP_LOOKUP, 32'd0, '0, '0);
		send_item(OP_STORE, 32'd0, '1, '1);
		send_item(OP_LOOKUP, 32'd1, '0, '0);
		send_item(OP_STORE, 32'd1, '0, '0);
		send_item(OP_LOOKUP, 32'd1, '1, '1);
		send_item(OP_STORE, 32'd1, '1, {16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF});
		send_item(OP_LOOKUP, 32'd1, '0, '0);
		send_item(OP_STORE, 32'hFFFF_FFFF, {32'h0000_0001, 32'h8000_0000},
			{16'h7FFF, 16'h8000, 16'h0001, 16'h8000});
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0);
		// cluster on the last slot so probing wraps to slot 0
		foreach (wrap_key[i])
			wrap_key[i] = key_for_slot(CAP - 1);
		for (int i = 0; i < 3; i++) begin
			stored_keys.push_back(wrap_key[i]);
			send_item(OP_STORE, wrap_key[i], rand_ia(), rand_geom());
		end
		for (int i = 2; i >= 0; i--)
			send_item(OP_LOOKUP, wrap_key[i], '0, '0);
		send_item(OP_LOOKUP, wrap_key[3], '0, '0);
		send_item(OP_STORE, wrap_key[1], rand_ia(), rand_geom());
		send_item(OP_LOOKUP, wrap_key[1], '0, '0);
		send_item(OP_STORE, 32'h8000_0000, rand_ia(), rand_geom());
		send_item(OP_LOOKUP, 32'h8000_0000, '0, '0);
		drain_results();

		// load limit already exceeded: new keys refused, updates still land
		write_limit(9'd1);
		send_item(OP_STORE, key_for_slot(7), rand_ia(), rand_geom());
		send_item(OP_STORE, wrap_key[0], rand_ia(), rand_geom());
		send_item(OP_LOOKUP, wrap_key[0], '0, '0);
		pick_hot_slots();
		run_random(60);
		drain_results();

		write_limit(9'($urandom_range(180, 100)));
		pick_hot_slots();
		run_random(300);
		// receiver holds off while the sender keeps offering
		rx_hold_req = 1'b1;
		run_random(250);
		drain_results();
		run_random(250);
		drain_results();

		write_limit(9'd255);
		pick_hot_slots();
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		run_random(150);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		run_random(450);
		drain_results();

		// fill every slot, then probe a table without a free slot
		write_limit(9'd256);
		while (sb.entries < CAP) begin
			k = $urandom;
			if (k != '0)
				stored_keys.push_back(k);
			send_item(OP_STORE, k, rand_ia(), rand_geom());
		end
		run_random(60);
		drain_results();

		if (sb.errors == 0 && sb.glyph_replies.size() == 0) begin
			$display("[fnv_linear_probe_hash_map] OK");
		end else begin
			$display("[fnv_linear_probe_hash_map] ERROR");
		end
		$finish;
	end

endmodule

// File: fnv_linear_probe_hash_map.f
rtl/fnvlp_pkg.sv
rtl/fnvlp_hash.sv
rtl/fnvlp_store.sv
rtl/fnv_linear_probe_hash_map.sv
tb/sv/testbench.sv
